// ===== sv/qcd_pkg.sv =====
// ----------------------------------------------------------------------------
// qcd_pkg: shared types and constants of the quadrature click decoder
// Register indexes, table codes, click codes and the structs that pass
// configuration and results between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qcd_pkg;

    localparam int unsigned PaddrW = 3;

    localparam logic RegSingleMode      = 1'b0;
    localparam logic RegTransitionTable = 1'b1;

    localparam logic [31:0] TableReset = 32'h3443_C11C;

    localparam logic [1:0] CodePlus  = 2'b01;
    localparam logic [1:0] CodeMinus = 2'b11;

    localparam logic signed [1:0] ClickPos = 2'sb01;
    localparam logic signed [1:0] ClickNeg = 2'sb11;

    localparam logic ChanA = 1'b0;

    typedef struct packed {
        logic        single_mode;
        logic [31:0] transition_table;
    } cfg_t;

    typedef struct packed {
        logic signed [1:0] click;
        logic              out_channel;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/qcd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// qcd_apb_regs: configuration registers
// APB write and read access to the mode bit and the transition table.
// ----------------------------------------------------------------------------
`default_nettype none

module qcd_apb_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [qcd_pkg::PaddrW-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output qcd_pkg::cfg_t                     cfg
);

    logic        single_mode_reg;
    logic        single_mode_next;
    logic [31:0] table_reg;
    logic [31:0] table_next;
    logic        wr_en;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        single_mode_next = single_mode_reg;
        table_next       = table_reg;
        if (wr_en)
        begin
            case (reg_idx)
                qcd_pkg::RegSingleMode:      single_mode_next = pwdata[0];
                qcd_pkg::RegTransitionTable: table_next       = pwdata;
                default:                     table_next       = table_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_mode_reg <= 1'b0;
            table_reg       <= qcd_pkg::TableReset;
        end
        else
        begin
            single_mode_reg <= single_mode_next;
            table_reg       <= table_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            qcd_pkg::RegSingleMode:      prdata = {31'd0, single_mode_reg};
            qcd_pkg::RegTransitionTable: prdata = table_reg;
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg.single_mode      = single_mode_reg;
    assign cfg.transition_table = table_reg;

endmodule

`default_nettype wire

// ===== sv/qcd_core.sv =====
// ----------------------------------------------------------------------------
// qcd_core: sample register, transition lookup and step accumulator
// Holds one sample, looks up its step from the old and new line pairs and
// emits a click when the accumulated steps reach a full detent.
// ----------------------------------------------------------------------------
`default_nettype none

module qcd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            level_a,
    input  wire logic            level_b,
    input  wire logic            source_channel,
    input  wire logic            slot_free,
    input  wire qcd_pkg::cfg_t   cfg,
    output logic                 res_valid,
    output qcd_pkg::result_t     res
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              a_reg;
    logic              b_reg;
    logic              src_reg;
    logic [1:0]        prev_pair_reg;
    logic [1:0]        prev_pair_next;
    logic signed [2:0] acc_reg;
    logic signed [2:0] acc_next;

    logic              advance;
    logic              take;
    logic [1:0]        pair;
    logic [3:0]        idx;
    logic [1:0]        code;
    logic signed [3:0] step;
    logic signed [3:0] sum;
    logic              hit;

    assign advance  = s1_valid_reg && slot_free;
    assign in_ready = !s1_valid_reg || advance;
    assign take     = in_valid && in_ready;

    assign pair = {a_reg, b_reg};
    assign idx  = {prev_pair_reg, pair};
    assign code = cfg.transition_table[{idx, 1'b0} +: 2];

    always_comb
    begin
        case (code)
            qcd_pkg::CodePlus:  step = 4'sd1;
            qcd_pkg::CodeMinus: step = -4'sd1;
            default:            step = 4'sd0;
        endcase
    end

    assign sum = {acc_reg[2], acc_reg} + step;
    assign hit = (sum == 4'sd4) || (sum == -4'sd4);

    always_comb
    begin
        s1_valid_next  = take || (s1_valid_reg && !advance);
        prev_pair_next = prev_pair_reg;
        acc_next       = acc_reg;
        if (advance)
        begin
            prev_pair_next = pair;
            acc_next       = hit ? 3'sd0 : sum[2:0];
        end
    end

    assign res_valid = advance && hit;

    always_comb
    begin
        if (cfg.single_mode)
        begin
            res.click       = sum[3] ? qcd_pkg::ClickNeg : qcd_pkg::ClickPos;
            res.out_channel = qcd_pkg::ChanA;
        end
        else
        begin
            res.click       = qcd_pkg::ClickPos;
            res.out_channel = src_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            prev_pair_reg <= 2'd0;
            acc_reg       <= 3'sd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            prev_pair_reg <= prev_pair_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_reg   <= level_a;
            b_reg   <= level_b;
            src_reg <= source_channel;
        end
    end

`ifndef SYNTHESIS
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg != -3'sd4)
        else $error("accumulator holds a full detent");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> acc_reg == 3'sd0)
        else $error("accumulator not cleared after click");

    a_pair_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> prev_pair_reg == $past(pair))
        else $error("previous pair not updated");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(acc_reg) && $stable(prev_pair_reg))
        else $error("state moved without a sample");
`endif

endmodule

`default_nettype wire

// ===== sv/quadrature_click_decoder.sv =====
// ----------------------------------------------------------------------------
// quadrature_click_decoder: rotary encoder click decoder
// Turns samples of the two quadrature lines into detent clicks.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready transfer one sample (level_a, level_b,
// source_channel). Output channel: out_valid/out_ready transfer one click
// (click, out_channel). A sample that completes a detent yields one click;
// any other sample yields nothing.
// Path: a click's sample passes the sample register, then the result
// register, before the click is on the output.
// Throughput: one sample per cycle while the output does not stall; the step
// lookup and accumulate are combinational between the two registers.
// Stall: while out_ready is low the held click waits in the result register;
// the sample register still drains if the result register is empty, then
// in_ready drops until the click is taken.
// Reset: clears both valid flags, the previous pair and the accumulator;
// single_mode returns to 0 and the table to its default.
// Configuration: APB at byte address 0 (single_mode) and 4
// (transition_table); write only while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_click_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [qcd_pkg::PaddrW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        level_a,
    input  wire logic                        level_b,
    input  wire logic                        source_channel,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [1:0]                click,
    output logic                             out_channel
);

    qcd_pkg::cfg_t    cfg;
    qcd_pkg::result_t res;
    logic             res_valid;
    logic             slot_free;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic signed [1:0] click_reg;
    logic             out_channel_reg;

    qcd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qcd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .level_a        (level_a),
        .level_b        (level_b),
        .source_channel (source_channel),
        .slot_free      (slot_free),
        .cfg            (cfg),
        .res_valid      (res_valid),
        .res            (res)
    );

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            click_reg       <= res.click;
            out_channel_reg <= res.out_channel;
        end
    end

    assign out_valid   = out_valid_reg;
    assign click       = click_reg;
    assign out_channel = out_channel_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for quadrature_click_decoder
// Feeds encoder line samples (mostly clean detent rotations in both directions,
// with repeats, illegal jumps and stray source channels mixed in) through the
// valid/ready sample port and checks every click against a cycle-free
// predictor of the step table and accumulator. Several configurations are
// written over APB between phases, including all-zero, all-plus, all-minus
// and all-code-two step tables. Both sides idle at random; one phase holds
// the click port off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int DetentSteps    = 4;
    localparam int LatencyCycles  = 4;
    localparam int HoldOffCycles  = 300;
    localparam int WatchdogLimit  = 2000;
    localparam int MaxReported    = 10;
    localparam int PhaseSamples   = 75;

    typedef struct packed {
        logic level_a;
        logic level_b;
        logic source_channel;
    } sample_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [qcd_pkg::PaddrW-1:0]   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         level_a = 1'b0;
    logic                         level_b = 1'b0;
    logic                         source_channel = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [1:0]            click;
    logic                         out_channel;

    sample_t                      sample_queue[$];
    qcd_pkg::result_t             pending_clicks[$];

    logic                         model_single = 1'b0;
    logic [31:0]                  model_table = qcd_pkg::TableReset;
    logic [1:0]                   model_prev_pair = '0;
    logic signed [2:0]            model_acc = '0;

    logic                         in_taken = 1'b0;
    logic                         out_taken = 1'b0;
    int                           queued_total = 0;
    int                           accepted_total = 0;
    int                           mismatches = 0;
    int                           idle_cycles = 0;

    int                           tx_gap_max = 0;
    int                           rx_stall_max = 0;
    int                           tx_gap = 0;
    int                           rx_wait = 0;
    bit                           hold_off_req = 1'b0;
    bit                           hold_off_started = 1'b0;
    int                           hold_off_left = 0;

    logic [1:0]                   gen_pair = '0;
    bit                           turning_cw = 1'b1;

    quadrature_click_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .level_a        (level_a),
        .level_b        (level_b),
        .source_channel (source_channel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .click          (click),
        .out_channel    (out_channel)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxReported)
        begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    task automatic advance_detent(input sample_t s);
        logic [1:0]       pair;
        logic [3:0]       idx;
        logic [1:0]       code;
        int               sum;
        qcd_pkg::result_t r;
        pair = {s.level_a, s.level_b};
        idx  = {model_prev_pair, pair};
        code = model_table[2*idx +: 2];
        sum  = model_acc;
        case (code)
            qcd_pkg::CodePlus:  sum = sum + 1;
            qcd_pkg::CodeMinus: sum = sum - 1;
            default:            sum = sum;
        endcase
        model_prev_pair = pair;
        if (sum == DetentSteps || sum == -DetentSteps)
        begin
            model_acc = '0;
            if (model_single)
            begin
                r.click       = (sum > 0) ? qcd_pkg::ClickPos : qcd_pkg::ClickNeg;
                r.out_channel = qcd_pkg::ChanA;
            end
            else
            begin
                r.click       = qcd_pkg::ClickPos;
                r.out_channel = s.source_channel;
            end
            pending_clicks.push_back(r);
        end
        else
        begin
            model_acc = sum[2:0];
        end
    endtask

    // sample port driver
    always @(negedge clk)
    begin
        sample_t s;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (in_taken)
            begin
                tx_gap = $urandom_range(0, tx_gap_max);
            end
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() != 0)
            begin
                s = sample_queue.pop_front();
                in_valid       <= 1'b1;
                level_a        <= s.level_a;
                level_b        <= s.level_b;
                source_channel <= s.source_channel;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // click port receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                rx_wait = $urandom_range(0, rx_stall_max);
            end
            if (hold_off_req && !hold_off_started)
            begin
                hold_off_left    = HoldOffCycles;
                hold_off_started = 1'b1;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        qcd_pkg::result_t exp_click;
        if (rst_n)
        begin
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (in_valid && in_ready)
            begin
                advance_detent('{level_a, level_b, source_channel});
                accepted_total <= accepted_total + 1;
            end
            if (out_valid && out_ready)
            begin
                if (pending_clicks.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected click %0d on channel %0d",
                                            click, out_channel));
                end
                else
                begin
                    exp_click = pending_clicks.pop_front();
                    if (click !== exp_click.click || out_channel !== exp_click.out_channel)
                    begin
                        flag_mismatch($sformatf("expected click %0d ch %0d, got click %0d ch %0d",
                                                exp_click.click, exp_click.out_channel,
                                                click, out_channel));
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("FAIL quadrature_click_decoder");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic a, input logic b, input logic src);
        sample_queue.push_back('{a, b, src});
        queued_total++;
        gen_pair = {a, b};
    endtask

    task automatic push_turn(input bit cw, input int count);
        logic a;
        logic b;
        logic src;
        for (int i = 0; i < count; i++)
        begin
            a   = cw ? ~gen_pair[0] : gen_pair[0];
            b   = cw ? gen_pair[1] : ~gen_pair[1];
            src = (a != gen_pair[1]) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 7) == 0)
            begin
                src = ~src;
            end
            push_sample(a, b, src);
        end
    endtask

    task automatic push_random(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    turning_cw = ~turning_cw;
                end
                push_turn(turning_cw, 1);
            end
            else if (pick == 7)
            begin
                push_sample(gen_pair[1], gen_pair[0], 1'($urandom_range(0, 1)));
            end
            else
            begin
                push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (accepted_total != queued_total || pending_clicks.size() != 0);
        repeat (LatencyCycles) @(negedge clk);
    endtask

    task automatic write_register(input logic reg_index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == qcd_pkg::RegSingleMode)
        begin
            model_single = value[0];
        end
        else
        begin
            model_table = value;
        end
    endtask

    task automatic run_phase(input logic single, input logic [31:0] steps, input int count,
                             input int tx_max, input int rx_max, input bit squeeze);
        wait_idle();
        write_register(qcd_pkg::RegSingleMode, {31'b0, single});
        write_register(qcd_pkg::RegTransitionTable, steps);
        @(posedge clk);
        tx_gap_max   = tx_max;
        rx_stall_max = rx_max;
        if (squeeze)
        begin
            hold_off_req = 1'b1;
        end
        push_random(count);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        tx_gap_max   = 14;
        rx_stall_max = 14;
        push_sample(1'b1, 1'b0, 1'b0);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b0, 1'b1, 1'b0);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b0, 1'b1, 1'b1);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b0, 1'b0, 1'b0);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b1, 1'b1, 1'b1);

        wait_idle();
        write_register(qcd_pkg::RegSingleMode, 32'd1);
        @(posedge clk);
        push_turn(1'b1, 4);
        push_turn(1'b0, 4);

        wait_idle();
        write_register(qcd_pkg::RegTransitionTable, 32'hAAAA_AAAA);
        @(posedge clk);
        push_turn(1'b1, 6);

        run_phase(1'b0, qcd_pkg::TableReset, PhaseSamples, 14, 14, 1'b0);
        run_phase(1'b1, qcd_pkg::TableReset, PhaseSamples, 0, 0, 1'b0);
        run_phase(1'b1, 32'hFFFF_FFFF, PhaseSamples, 0, 14, 1'b1);
        run_phase(1'b0, 32'h5555_5555, PhaseSamples, 14, 3, 1'b0);
        run_phase(1'b0, 32'h0000_0000, 20, 3, 14, 1'b0);
        run_phase(1'($urandom_range(0, 1)), $urandom, PhaseSamples, 14, 14, 1'b0);
        run_phase(1'b1, $urandom, PhaseSamples, 5, 0, 1'b0);
        run_phase(1'b0, $urandom, PhaseSamples, 0, 5, 1'b0);

        wait_idle();
        if (pending_clicks.size() != 0)
        begin
            flag_mismatch($sformatf("%0d clicks never arrived", pending_clicks.size()));
        end
        if (mismatches == 0)
        begin
            $display("PASS quadrature_click_decoder");
        end
        else
        begin
            $display("FAIL quadrature_click_decoder");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/qcd_pkg.sv
sv/qcd_apb_regs.sv
sv/qcd_core.sv
sv/quadrature_click_decoder.sv
test/tb.sv
